@@ src/lxp_pkg.sv @@
// Shared types and constants for the lung xorshift random generator.
package lxp_pkg;

	typedef enum logic [1:0] {
		OP_SEED    = 2'd0,
		OP_DRAW32  = 2'd1,
		OP_DRAW64  = 2'd2,
		OP_DRAW128 = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] seed;
	} cmd_t;

	typedef struct packed {
		logic [7:0]       pick_distance;
		logic [4:0]       word_left_shift;
		logic [2:0]       byte_left_shift;
		logic [4:0]       word_right_shift;
		logic [3:0][31:0] mask_word;
	} cfg_t;

	localparam logic [31:0] SEED_MULT  = 32'd1812433253;
	localparam int unsigned SEED_SHIFT = 30;

	localparam int unsigned CFG_ADDR_W = 5;

	localparam logic [2:0] REG_PICK_DISTANCE    = 3'd0;
	localparam logic [2:0] REG_WORD_LEFT_SHIFT  = 3'd1;
	localparam logic [2:0] REG_BYTE_LEFT_SHIFT  = 3'd2;
	localparam logic [2:0] REG_WORD_RIGHT_SHIFT = 3'd3;
	localparam logic [2:0] REG_MASK_WORD0       = 3'd4;
	localparam logic [2:0] REG_MASK_WORD1       = 3'd5;
	localparam logic [2:0] REG_MASK_WORD2       = 3'd6;
	localparam logic [2:0] REG_MASK_WORD3       = 3'd7;

endpackage

@@ src/lxp_if.sv @@
// Request and response channel interfaces of the random generator.
interface lxp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] seed;

	modport source (output valid, output operation, output seed, input ready);
	modport sink (input valid, input operation, input seed, output ready);
endinterface

interface lxp_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_low;
	logic [63:0] result_high;
	logic        status;

	modport source (output valid, output result_low, output result_high, output status,
		input ready);
	modport sink (input valid, input result_low, input result_high, input status,
		output ready);
endinterface

@@ src/lxp_front.sv @@
// Request front end: takes transfers, decodes the operation and queues commands.
module lxp_front
	import lxp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	lxp_req_if.sink req,
	output cmd_t  cmd,
	output logic  cmd_valid,
	input  logic  cmd_ready
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign req.ready = (count_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{op: op_t'(req.operation), seed: req.seed};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

@@ src/lxp_engine.sv @@
// Back end: ring memory, lung, regeneration, seeding and draw delivery.
module lxp_engine
	import lxp_pkg::*;
#(
	parameter int unsigned RING_ENTRIES = 156
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  cmd_t  cmd,
	input  logic  cmd_valid,
	output logic  cmd_ready,
	lxp_rsp_if.source rsp
);

	localparam int unsigned EW = $clog2(RING_ENTRIES);
	localparam int unsigned IW = EW + 2;
	localparam int unsigned KW = $clog2(4 * (RING_ENTRIES + 1));
	localparam int unsigned SW = ((EW > 8) ? EW : 8) + 1;
	localparam logic [KW-1:0] KLAST = KW'(4 * (RING_ENTRIES + 1) - 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MODB, S_RA, S_RB, S_RC, S_CALC, S_RE, S_RX,
		S_SPUT, S_SMUL, S_SADD, S_DELIVER
	} state_t;

	state_t      state_q;
	op_t         op_q;
	logic [IW-1:0] idx_q;
	logic [EW-1:0] clr_q;
	logic [SW-1:0] bsum_q;
	logic [KW-1:0] k_q;
	logic [31:0]  cur_q;
	logic [31:0]  prod_q;
	logic [127:0] wbuf_q;
	logic [127:0] lung_q;
	logic [127:0] a_q;
	logic [127:0] b_q;
	logic [127:0] ent_q;
	logic [127:0] rdata_q;
	logic         out_valid_q;
	logic [63:0]  rlo_q;
	logic [63:0]  rhi_q;
	logic         st_q;

	logic [127:0] ring_mem [RING_ENTRIES];

	logic [EW-1:0] e;
	logic [1:0]    w;
	logic [EW-1:0] c_idx;
	logic          rd_en;
	logic [EW-1:0] rd_addr;
	logic          wr_en;
	logic [EW-1:0] wr_addr;
	logic [127:0]  wr_data;
	logic [127:0]  x;
	logic [127:0]  dperm;
	logic [127:0]  n;
	logic [127:0]  full_entry;
	logic [KW-3:0] k_ent;
	logic [IW:0]   nidx;
	logic [2:0]    step;

	assign e          = idx_q[IW-1:2];
	assign w          = idx_q[1:0];
	assign c_idx      = (e == '0) ? EW'(RING_ENTRIES - 1) : e - EW'(1);
	assign full_entry = {cur_q, wbuf_q[95:0]};
	assign k_ent      = k_q[KW-1:2];
	assign cmd_ready  = (state_q == S_IDLE) && !out_valid_q;

	assign rsp.valid       = out_valid_q;
	assign rsp.result_low  = rlo_q;
	assign rsp.result_high = rhi_q;
	assign rsp.status      = st_q;

	// New entry from the current, distant and previous entries and the permuted lung.
	assign x     = a_q << {cfg.byte_left_shift, 3'b000};
	assign dperm = {lung_q[63:32], lung_q[31:0], lung_q[95:64], lung_q[127:96]};
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			n[k*32 +: 32] = a_q[k*32 +: 32] ^ x[k*32 +: 32]
				^ ((b_q[k*32 +: 32] >> cfg.word_right_shift) & cfg.mask_word[k])
				^ (rdata_q[k*32 +: 32] << cfg.word_left_shift)
				^ dperm[k*32 +: 32];
		end
	end

	always_comb begin
		unique case (op_q)
			OP_DRAW32: step = 3'd1;
			OP_DRAW64: step = 3'd2;
			default:   step = 3'd4;
		endcase
		nidx = {1'b0, idx_q} + (IW+1)'(step);
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = e;
		wr_en   = 1'b0;
		wr_addr = e;
		wr_data = n;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_RA, S_RE: begin
				rd_en = 1'b1;
			end
			S_RB: begin
				rd_en   = 1'b1;
				rd_addr = bsum_q[EW-1:0];
			end
			S_RC: begin
				rd_en   = 1'b1;
				rd_addr = c_idx;
			end
			S_CALC: begin
				wr_en = 1'b1;
			end
			S_SPUT: begin
				wr_en   = (k_q[1:0] == 2'd3) && ((KW-2)'(k_ent) < (KW-2)'(RING_ENTRIES));
				wr_addr = EW'(k_ent);
				wr_data = full_entry;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			idx_q       <= '0;
			lung_q      <= '0;
			out_valid_q <= 1'b0;
			op_q        <= OP_SEED;
			bsum_q      <= '0;
			k_q         <= '0;
			cur_q       <= '0;
			prod_q      <= '0;
			wbuf_q      <= '0;
			a_q         <= '0;
			b_q         <= '0;
			ent_q       <= '0;
			rlo_q       <= '0;
			rhi_q       <= '0;
			st_q        <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + EW'(1);
					if (clr_q == EW'(RING_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						op_q   <= cmd.op;
						bsum_q <= SW'(e) + SW'(cfg.pick_distance);
						unique case (cmd.op)
							OP_SEED: begin
								cur_q   <= cmd.seed;
								k_q     <= '0;
								state_q <= S_SPUT;
							end
							OP_DRAW32: begin
								state_q <= (w == 2'd0) ? S_MODB : S_RE;
							end
							OP_DRAW64: begin
								if (w[0]) begin
									out_valid_q <= 1'b1;
									rlo_q       <= '0;
									rhi_q       <= '0;
									st_q        <= 1'b1;
								end else begin
									state_q <= (w == 2'd0) ? S_MODB : S_RE;
								end
							end
							OP_DRAW128: begin
								if (w != 2'd0) begin
									out_valid_q <= 1'b1;
									rlo_q       <= '0;
									rhi_q       <= '0;
									st_q        <= 1'b1;
								end else begin
									state_q <= S_MODB;
								end
							end
						endcase
					end
				end
				S_MODB: begin
					// Reduce the distant entry index modulo the ring size.
					if (bsum_q >= SW'(RING_ENTRIES)) begin
						bsum_q <= bsum_q - SW'(RING_ENTRIES);
					end else begin
						state_q <= S_RA;
					end
				end
				S_RA: state_q <= S_RB;
				S_RB: begin
					a_q     <= rdata_q;
					state_q <= S_RC;
				end
				S_RC: begin
					b_q     <= rdata_q;
					state_q <= S_CALC;
				end
				S_CALC: begin
					ent_q   <= n;
					lung_q  <= lung_q ^ n;
					state_q <= S_DELIVER;
				end
				S_RE: state_q <= S_RX;
				S_RX: begin
					ent_q   <= rdata_q;
					state_q <= S_DELIVER;
				end
				S_DELIVER: begin
					out_valid_q <= 1'b1;
					st_q        <= 1'b0;
					unique case (op_q)
						OP_DRAW32: begin
							rlo_q <= {32'd0, ent_q[w*32 +: 32]};
							rhi_q <= '0;
						end
						OP_DRAW64: begin
							rlo_q <= ent_q[w*32 +: 64];
							rhi_q <= '0;
						end
						default: begin
							rlo_q <= ent_q[63:0];
							rhi_q <= ent_q[127:64];
						end
					endcase
					if (nidx >= (IW+1)'(4 * RING_ENTRIES)) begin
						idx_q <= '0;
					end else begin
						idx_q <= nidx[IW-1:0];
					end
					state_q <= S_IDLE;
				end
				S_SPUT: begin
					wbuf_q[k_q[1:0]*32 +: 32] <= cur_q;
					if ((k_q[1:0] == 2'd3) && ((KW-2)'(k_ent) == (KW-2)'(RING_ENTRIES))) begin
						lung_q <= full_entry;
					end
					if (k_q == KLAST) begin
						idx_q       <= '0;
						out_valid_q <= 1'b1;
						rlo_q       <= '0;
						rhi_q       <= '0;
						st_q        <= 1'b0;
						state_q     <= S_IDLE;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= S_SMUL;
					end
				end
				S_SMUL: begin
					prod_q  <= SEED_MULT * (cur_q ^ (cur_q >> SEED_SHIFT));
					state_q <= S_SADD;
				end
				S_SADD: begin
					cur_q   <= prod_q + 32'(k_q);
					state_q <= S_SPUT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ src/lung_xorshift_128bit_prng_core.sv @@
// Top level of the lung xorshift random generator with its register port.
// Requests arrive on req (operation, seed) and each one yields exactly one
// transfer on rsp (result_low, result_high, status). A two-entry command
// queue sits in front of the engine, so requests are taken while a result
// waits for the receiver; when the receiver stalls, the engine holds its
// output register and stops, and the queue then fills and drops req.ready.
// After reset the engine clears the ring memory, one entry per cycle,
// before it takes the first request; the lung and the word index reset to
// zero at once. Register writes are taken at any time. A draw within an
// entry reads it in S_RE and S_RX and answers from S_DELIVER; a draw that
// regenerates an entry first reduces the distant entry index in S_MODB,
// one subtraction of RING_ENTRIES per wrap, then makes three reads of the
// ring memory (one read port) in S_RA, S_RB and S_RC before S_CALC.
// A misaligned draw answers straight from S_IDLE. A seed steps through
// S_SPUT, S_SMUL and S_SADD for each word, one multiply per word.
// One request is worked on at a time.
module lung_xorshift_128bit_prng_core
	import lxp_pkg::*;
#(
	parameter int unsigned RING_ENTRIES = 156
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	lxp_req_if.sink               req,
	lxp_rsp_if.source             rsp
);

	cfg_t       cfg_q;
	cmd_t       cmd;
	logic       cmd_valid;
	logic       cmd_ready;
	logic [2:0] reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[CFG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pick_distance    <= 8'd1;
			cfg_q.word_left_shift  <= 5'd11;
			cfg_q.byte_left_shift  <= 3'd1;
			cfg_q.word_right_shift <= 5'd7;
			cfg_q.mask_word        <= {4{32'd7}};
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_PICK_DISTANCE:    cfg_q.pick_distance    <= pwdata[7:0];
				REG_WORD_LEFT_SHIFT:  cfg_q.word_left_shift  <= pwdata[4:0];
				REG_BYTE_LEFT_SHIFT:  cfg_q.byte_left_shift  <= pwdata[2:0];
				REG_WORD_RIGHT_SHIFT: cfg_q.word_right_shift <= pwdata[4:0];
				REG_MASK_WORD0:       cfg_q.mask_word[0]     <= pwdata;
				REG_MASK_WORD1:       cfg_q.mask_word[1]     <= pwdata;
				REG_MASK_WORD2:       cfg_q.mask_word[2]     <= pwdata;
				REG_MASK_WORD3:       cfg_q.mask_word[3]     <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_PICK_DISTANCE:    prdata = {24'd0, cfg_q.pick_distance};
			REG_WORD_LEFT_SHIFT:  prdata = {27'd0, cfg_q.word_left_shift};
			REG_BYTE_LEFT_SHIFT:  prdata = {29'd0, cfg_q.byte_left_shift};
			REG_WORD_RIGHT_SHIFT: prdata = {27'd0, cfg_q.word_right_shift};
			REG_MASK_WORD0:       prdata = cfg_q.mask_word[0];
			REG_MASK_WORD1:       prdata = cfg_q.mask_word[1];
			REG_MASK_WORD2:       prdata = cfg_q.mask_word[2];
			REG_MASK_WORD3:       prdata = cfg_q.mask_word[3];
		endcase
	end

	lxp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	lxp_engine #(
		.RING_ENTRIES (RING_ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp       (rsp)
	);

endmodule
